/* src/wcrt_pkg.sv */
// ----------------------------------------------------------------------------
// wcrt_pkg
// shared types and constants of the windowed change rate table
// ----------------------------------------------------------------------------
package wcrt_pkg;

  localparam int unsigned CHUNK_SLOTS = 64;
  localparam int unsigned RING_DEPTH  = 16;

  localparam int unsigned RateW  = 34;
  localparam int unsigned FrameW = 32;
  localparam int unsigned SwapW  = 16;
  localparam logic [RateW-1:0] RateMax = {RateW{1'b1}};

  typedef enum logic [1:0] {
    ActRecord = 2'd0,
    ActQuery  = 2'd1,
    ActForget = 2'd2,
    ActClear  = 2'd3
  } action_e;

  typedef enum logic [0:0] {
    RegWindow = 1'b0,
    RegThresh = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StWalk,
    StDiv,
    StOut
  } state_e;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [39:0] num;
    logic [31:0] den;
  } div_req_t;

endpackage

/* src/windowed_change_rate_table.sv */
// ----------------------------------------------------------------------------
// windowed_change_rate_table
// per-slot rings of (frame, swaps) records with windowed rate queries
// ----------------------------------------------------------------------------
// one command word enters on s_axis; only a query produces a word on m_axis
// record/forget: the word is accepted, then passes one slot table read (StRead)
// clear: the word is accepted, then the slot table is swept, one slot per
// cycle, with s_axis_tready low
// query: a slot read, a walk over the included records (one record per cycle
// through the single read port of the record memory), the bit-serial divider
// when the span is nonzero, then the output register is written
// after reset the slot table is swept clear before the first word is
// accepted; configuration writes belong to idle periods
// a finished result waits in the output register; a stalled receiver lets
// records, forgets and clears through, while the next query parks in its
// output cycle and holds s_axis_tready low until the waiting word is taken
// registers: 0 window_frames (reset 60), 1 settle_threshold (reset 256),
// at byte addresses 0 and 8
// ----------------------------------------------------------------------------
module windowed_change_rate_table import wcrt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // action[1:0], slot[7:2], frame[39:8], swap_count[55:40],
  // query_threshold[89:56], use_query_threshold[90]
  input  logic [95:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // rate[33:0], settling[34], records_held[39:35]
  output logic [39:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  localparam int unsigned SW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
  localparam int unsigned RW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned FW = $clog2(RING_DEPTH + 1);
  localparam int unsigned MD = CHUNK_SLOTS * RING_DEPTH;

  // configuration
  logic [31:0]      window_q;
  logic [RateW-1:0] thresh_q;
  logic             cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= 32'd60;
      thresh_q <= 34'd256;
    end else if (cfg_wr && paddr == {RegWindow, 3'b000}) begin
      window_q <= pwdata[31:0];
    end else if (cfg_wr && paddr == {RegThresh, 3'b000}) begin
      thresh_q <= pwdata[RateW-1:0];
    end
  end
  always_comb begin
    prdata = '0;
    if (paddr == {RegWindow, 3'b000}) prdata = {32'd0, window_q};
    else if (paddr == {RegThresh, 3'b000}) prdata = {30'd0, thresh_q};
  end

  // memories
  logic [FrameW+SwapW-1:0] rec_mem [MD];
  logic [RW+FW-1:0]        slot_mem [CHUNK_SLOTS];
  logic [FrameW+SwapW-1:0] rec_rd;
  logic [RW+FW-1:0]        slot_rd;

  // command register
  logic [1:0]       act_q;
  logic [5:0]       slot_in_q;
  logic [31:0]      frame_q;
  logic [15:0]      swp_q;
  logic [RateW-1:0] thr_q;
  logic             valid_slot;

  state_e           st_q, st_d;
  logic [SW:0]      sweep_q;
  logic             sweeping_q;
  logic [RW-1:0]    head_q;
  logic [FW-1:0]    fill_q, idx_q;
  logic [31:0]      newest_q, win_q, oldest_q;
  logic [20:0]      sum_q;
  logic             first_q;
  logic [RateW-1:0] rate_q;
  logic [39:0]      out_q;
  logic             ovalid_q;
  logic             out_fire;
  div_req_t         dreq;
  logic             ddone;
  logic [39:0]      dquot;

  assign valid_slot = {26'd0, slot_in_q} < 32'(CHUNK_SLOTS);
  wire [SW-1:0] slot_a = slot_in_q[SW-1:0];
  wire accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = st_q == StIdle && !sweeping_q;
  // result leaves the query path once the output register is free
  assign out_fire = st_q == StOut && (!ovalid_q || m_axis_tready);

  // physical ring position for logical index
  function automatic logic [RW-1:0] pos(input logic [FW-1:0] fill,
                                        input logic [RW-1:0] head,
                                        input logic [FW-1:0] li);
    logic [FW:0] p;
    p = (fill < FW'(RING_DEPTH)) ? {1'b0, li} : {1'b0, li} + (FW+1)'(head);
    if (p >= (FW+1)'(RING_DEPTH)) p = p - (FW+1)'(RING_DEPTH);
    return p[RW-1:0];
  endfunction

  logic [RW-1:0] rd_pos;
  logic [31:0]   rfr;
  logic [15:0]   rsw;
  logic [FW-1:0] rd_fill, rd_li;
  logic [RW-1:0] rd_head;
  logic          walk_more;
  assign rfr = rec_rd[47:16];
  assign rsw = rec_rd[15:0];
  assign walk_more = st_q == StWalk && !first_q && !(idx_q == '0 || rfr < win_q);

  // read address runs one record ahead of the walk: the newest record is
  // fetched during the slot read, each walk step fetches the next one
  assign rd_fill = (st_q == StRead) ? slot_rd[FW-1:0] : fill_q;
  assign rd_head = (st_q == StRead) ? slot_rd[RW+FW-1:FW] : head_q;
  always_comb begin
    if (st_q == StRead) rd_li = slot_rd[FW-1:0] - FW'(1);
    else if (st_q == StWalk && (first_q || walk_more)) rd_li = idx_q - FW'(2);
    else rd_li = idx_q - FW'(1);
  end
  assign rd_pos = pos(rd_fill, rd_head, rd_li);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= s_axis_tdata[1:0]; slot_in_q <= s_axis_tdata[7:2];
      frame_q <= s_axis_tdata[39:8]; swp_q <= s_axis_tdata[55:40];
      thr_q <= s_axis_tdata[90] ? s_axis_tdata[89:56] : thresh_q;
    end
    if (accept) slot_rd <= slot_mem[s_axis_tdata[2+SW-1:2]];
    rec_rd <= rec_mem[{slot_a, rd_pos}];
    if (st_q == StRead && act_q == ActRecord && valid_slot)
      rec_mem[{slot_a, slot_rd[RW+FW-1:FW]}] <= {frame_q, swp_q};
    if (sweeping_q)
      slot_mem[sweep_q[SW-1:0]] <= '0;
    else if (st_q == StRead && valid_slot && act_q == ActRecord)
      slot_mem[slot_a] <= {(slot_rd[RW+FW-1:FW] == RW'(RING_DEPTH - 1)) ? RW'(0) :
                           slot_rd[RW+FW-1:FW] + RW'(1),
                           (slot_rd[FW-1:0] < FW'(RING_DEPTH)) ? slot_rd[FW-1:0] + FW'(1)
                                                              : slot_rd[FW-1:0]};
    else if (st_q == StRead && valid_slot && act_q == ActForget)
      slot_mem[slot_a] <= '0;
  end

  always_comb begin
    st_d = st_q;
    dreq = '0;
    case (st_q)
      StIdle: if (accept && s_axis_tdata[1:0] != ActClear) st_d = StRead;
      StRead: st_d = (act_q == ActQuery) ? StWalk : StIdle;
      StWalk: begin
        if (!valid_slot || fill_q <= FW'(1)) st_d = StOut;
        else if (!first_q && (idx_q == '0 || rfr < win_q)) begin
          if (newest_q == oldest_q) st_d = StOut;
          else begin
            st_d = StDiv;
            dreq.start = 1'b1;
            dreq.num = {5'd0, sum_q, 14'd0} - {9'd0, sum_q, 10'd0};
            dreq.den = newest_q - oldest_q;
          end
        end
      end
      StDiv: if (ddone) st_d = StOut;
      StOut: if (out_fire) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  wcrt_div u_div (.clk_i, .rst_ni, .req_i(dreq), .done_o(ddone), .quot_o(dquot));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; sweeping_q <= 1'b1; sweep_q <= '0; ovalid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (accept && s_axis_tdata[1:0] == ActClear) begin
        sweeping_q <= 1'b1; sweep_q <= '0;
      end else if (sweeping_q) begin
        sweep_q <= sweep_q + 1'b1;
        if (sweep_q == (SW+1)'(CHUNK_SLOTS - 1)) sweeping_q <= 1'b0;
      end
      if (out_fire) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  // query walk, one record per cycle, newest first
  always_ff @(posedge clk_i) begin
    case (st_q)
      StRead: begin
        head_q <= slot_rd[RW+FW-1:FW];
        fill_q <= slot_rd[FW-1:0];
        idx_q <= slot_rd[FW-1:0];
        first_q <= 1'b1; sum_q <= '0; rate_q <= '0;
      end
      StWalk: begin
        if (first_q) begin
          first_q <= 1'b0;
          newest_q <= rfr; oldest_q <= rfr;
          win_q <= (rfr >= window_q) ? rfr - window_q : 32'd0;
          sum_q <= 21'(rsw);
          idx_q <= idx_q - FW'(1);
          if (fill_q == FW'(1)) rate_q <= {10'd0, rsw, 8'd0};
        end else if (!(idx_q == '0 || rfr < win_q)) begin
          sum_q <= sum_q + 21'(rsw);
          oldest_q <= rfr;
          idx_q <= idx_q - FW'(1);
        end else if (newest_q == oldest_q) begin
          rate_q <= {5'd0, sum_q, 8'd0};
        end
      end
      StDiv: if (ddone) rate_q <= (dquot[39:RateW] != '0) ? RateMax : dquot[RateW-1:0];
      default: ;
    endcase
    if (out_fire) begin
      out_q[33:0] <= valid_slot ? rate_q : '0;
      out_q[34] <= valid_slot && rate_q != '0 && rate_q <= thr_q;
      out_q[39:35] <= valid_slot ? 5'(fill_q) : 5'd0;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = out_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> !s_axis_tready) else $error("accept while busy");
  a_out_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |-> act_q == ActQuery) else $error("result without query");
  a_div_only_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dreq.start |-> dreq.den != '0) else $error("zero divisor");
endmodule

/* src/wcrt_div.sv */
// ----------------------------------------------------------------------------
// wcrt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module wcrt_div import wcrt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  div_req_t    req_i,
  output logic        done_o,
  output logic [39:0] quot_o
);
  logic [39:0] q_q, q_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    q_d = q_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    trial = {rem_q[31:0], q_q[39]};
    if (req_i.start) begin
      q_d = req_i.num; rem_d = '0; den_d = req_i.den; cnt_d = 6'd40; busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        q_d = {q_q[38:0], 1'b1};
      end else begin
        rem_d = trial;
        q_d = {q_q[38:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = q_q;
endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench of the windowed change rate table: command words are
// driven on s_axis, query results on m_axis are compared against a local rate
// predictor, the two registers are written over apb between phases
// ----------------------------------------------------------------------------
module tb_top import wcrt_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 64;
  localparam int unsigned DEPTH = 16;
  localparam longint unsigned RMAX = 64'h3_FFFF_FFFF;
  localparam logic [3:0] AddrWindow = 4'd0;  // register 0 at byte 0
  localparam logic [3:0] AddrThresh = 4'd8;  // 34-bit register, so 8*i

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // action, slot, frame, swap_count, query_threshold, use_query_threshold
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // rate, settling, records_held
  logic [39:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  windowed_change_rate_table u_top (.*);

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #50_000_000;
    $display("[windowed_change_rate_table] ERROR");
    $finish;
  end

  // predictor state
  logic [31:0] rec_frame [NSLOT*DEPTH];
  logic [15:0] rec_swap  [NSLOT*DEPTH];
  int unsigned head_q [NSLOT];
  int unsigned fill_q [NSLOT];
  logic [31:0] win_reg;
  logic [33:0] thr_reg;

  logic [39:0] rate_expected_q [$];
  int          n_errors = 0;
  bit          stall_en = 1'b1;   // random idling of the receiver
  int          hold_cycles = 0;   // long receiver hold-off
  int          idle_pct = 17;

  function automatic int unsigned ring_pos(int unsigned s, int unsigned lg);
    int unsigned st;
    st = (fill_q[s] < DEPTH) ? 0 : head_q[s];
    return s * DEPTH + (st + lg) % DEPTH;
  endfunction

  function automatic logic [33:0] slot_rate(int unsigned s);
    int unsigned n, p;
    logic [31:0] newest, wstart, oldest, span;
    longint unsigned sum, r;
    n = fill_q[s];
    sum = 0;
    if (n == 0) return '0;
    if (n == 1) return 34'(rec_swap[ring_pos(s, 0)]) << 8;
    newest = rec_frame[ring_pos(s, n - 1)];
    wstart = (newest >= win_reg) ? newest - win_reg : 32'd0;
    oldest = newest;
    for (int i = int'(n) - 1; i >= 0; i--) begin
      p = ring_pos(s, i);
      if (rec_frame[p] < wstart) break;
      sum += rec_swap[p];
      oldest = rec_frame[p];
    end
    span = newest - oldest;
    if (span == 0) r = sum << 8;
    else r = (sum * 60 * 256) / span;
    return (r > RMAX) ? RMAX[33:0] : r[33:0];
  endfunction

  // updates the tables and pushes the expected word of a query
  task automatic predict_word(logic [95:0] w);
    action_e     act;
    int unsigned s;
    logic [33:0] r, thr;
    act = action_e'(w[1:0]);
    s = 32'(w[7:2]);
    case (act)
      ActRecord: begin
        rec_frame[s*DEPTH + head_q[s]] = w[39:8];
        rec_swap[s*DEPTH + head_q[s]]  = w[55:40];
        head_q[s] = (head_q[s] + 1) % DEPTH;
        if (fill_q[s] < DEPTH) fill_q[s]++;
      end
      ActQuery: begin
        thr = w[90] ? w[89:56] : thr_reg;
        r = slot_rate(s);
        rate_expected_q.push_back({5'(fill_q[s]), (r != 0 && r <= thr), r});
      end
      ActForget: begin
        fill_q[s] = 0;
        head_q[s] = 0;
      end
      default: begin
        foreach (fill_q[i]) begin
          fill_q[i] = 0;
          head_q[i] = 0;
        end
      end
    endcase
  endtask

  function automatic logic [95:0] pack_word(action_e a, int unsigned s, logic [31:0] f,
                                            logic [15:0] sw, logic [33:0] qt, bit uq);
    return {5'd0, uq, qt, sw, f, 6'(s), a};
  endfunction

  // starts and ends at a falling edge; valid stays up between back-to-back words
  task automatic send_word(logic [95:0] w, bit gaps);
    if (gaps)
      while ($urandom_range(99) < idle_pct) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    s_axis_tdata  <= w;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(w);
    @(negedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] a, logic [63:0] d);
    @(negedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= a; pwdata <= d; penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (a == AddrWindow) win_reg = d[31:0];
    else thr_reg = d[33:0];
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drop valid, drain, let a clear sweep finish, end on a falling edge
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (rate_expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver side
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= !(stall_en && $urandom_range(99) < idle_pct);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rate_expected_q.size() == 0) begin
        $display("%0t unexpected word: got %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        logic [39:0] e;
        e = rate_expected_q.pop_front();
        if (m_axis_tdata[33:0] !== e[33:0])
          $display("%0t rate mismatch: expected %h got %h", $time, e[33:0],
                   m_axis_tdata[33:0]);
        if (m_axis_tdata[34] !== e[34])
          $display("%0t settling mismatch: expected %b got %b", $time, e[34],
                   m_axis_tdata[34]);
        if (m_axis_tdata[39:35] !== e[39:35])
          $display("%0t records_held mismatch: expected %0d got %0d", $time, e[39:35],
                   m_axis_tdata[39:35]);
        if (m_axis_tdata !== e) n_errors++;
      end
    end
  end

  // directed rows: action, slot, frame, swaps, qthr, use_q, check of typed value
  typedef struct {
    action_e     act;
    int unsigned slot;
    logic [31:0] frame;
    logic [15:0] swaps;
    logic [33:0] qthr;
    bit          use_q;
    bit          typed;       // typed expectation present
    logic [39:0] typed_word;  // records_held, settling, rate
  } row_t;

  row_t rows [] = '{
    // empty slot after reset: rate 0
    '{ActQuery,  0, 0, 0, 0, 0, 1, 40'd0},
    '{ActQuery, 63, 0, 0, 34'h3_FFFF_FFFF, 1, 1, 40'd0},
    // one record gives swaps << 8
    '{ActRecord, 0, 100, 16'hFFFF, 0, 0, 0, 0},
    '{ActQuery,  0, 0, 0, 0, 0, 1, {5'd1, 1'b0, 34'(16'hFFFF) << 8}},
    '{ActRecord, 63, 32'hFFFF_FFFF, 1, 0, 0, 0, 0},
    '{ActQuery, 63, 0, 0, 0, 0, 1, {5'd1, 1'b1, 34'd256}},
    // zero span gives the sum << 8
    '{ActRecord, 63, 32'hFFFF_FFFF, 2, 0, 0, 0, 0},
    '{ActQuery, 63, 0, 0, 34'd768, 1, 1, {5'd2, 1'b1, 34'd768}},
    // normal span
    '{ActRecord, 0, 130, 16'h1234, 0, 0, 0, 0},
    '{ActQuery,  0, 0, 0, 34'h3_FFFF_FFFF, 1, 0, 0},
    // frames out of order, wrapping span
    '{ActRecord, 0, 5, 7, 0, 0, 0, 0},
    '{ActQuery,  0, 0, 0, 0, 0, 0, 0},
    // forget empties the slot
    '{ActForget, 0, 0, 0, 0, 0, 0, 0},
    '{ActQuery,  0, 0, 0, 0, 0, 1, 40'd0},
    '{ActRecord, 0, 1, 3, 0, 0, 0, 0},
    '{ActQuery,  0, 0, 0, 0, 0, 0, 0},
    // clear empties every slot
    '{ActClear,  5, 32'hFFFF_FFFF, 16'hFFFF, 34'h3_FFFF_FFFF, 1, 0, 0},
    '{ActQuery, 63, 0, 0, 0, 0, 1, 40'd0},
    '{ActQuery,  0, 0, 0, 0, 0, 1, 40'd0}
  };

  // well-formed history on the slots below slot_span with occasional noise
  task automatic random_phase(int n, int unsigned slot_span);
    logic [31:0] fr [NSLOT];
    int unsigned s, k;
    foreach (fr[i]) fr[i] = $urandom();
    for (int i = 0; i < n; i++) begin
      s = $urandom_range(slot_span - 1);
      k = $urandom_range(99);
      if (k < 55) begin
        fr[s] += ($urandom_range(9) == 0) ? $urandom() : $urandom_range(8);
        send_word(pack_word(ActRecord, s, fr[s],
                            ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($urandom_range(40)),
                            34'({$urandom(), $urandom()}), 1'($urandom_range(1))), 1'b1);
      end else if (k < 93) begin
        send_word(pack_word(ActQuery, s, $urandom(), 16'($urandom()),
                            ($urandom_range(1) ? 34'($urandom_range(4096))
                                               : 34'({$urandom(), $urandom()})),
                            1'($urandom_range(1))), 1'b1);
      end else if (k < 98) begin
        send_word(pack_word(ActForget, s, $urandom(), 16'($urandom()), 34'($urandom()),
                            1'($urandom_range(1))), 1'b1);
      end else begin
        send_word(pack_word(ActClear, $urandom_range(63), $urandom(), 16'($urandom()),
                            34'($urandom()), 1'($urandom_range(1))), 1'b1);
      end
    end
  endtask

  initial begin
    logic [95:0] w;
    foreach (fill_q[i]) begin
      fill_q[i] = 0;
      head_q[i] = 0;
    end
    foreach (rec_frame[i]) begin
      rec_frame[i] = '0;
      rec_swap[i] = '0;
    end
    win_reg = 32'd60;
    thr_reg = 34'd256;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    foreach (rows[i]) begin
      w = pack_word(rows[i].act, rows[i].slot, rows[i].frame, rows[i].swaps,
                    rows[i].qthr, rows[i].use_q);
      send_word(w, 1'b0);
      if (rows[i].typed && rate_expected_q[$] !== rows[i].typed_word) begin
        $display("%0t table row %0d: typed %h predictor %h", $time, i,
                 rows[i].typed_word, rate_expected_q[$]);
        n_errors++;
      end
    end
    wait_quiet();

    // register extremes and a few settings between phases
    apb_write(AddrWindow, 64'd0);
    apb_write(AddrThresh, 64'h3_FFFF_FFFF);
    random_phase(250, 4);
    wait_quiet();
    apb_write(AddrWindow, 64'hFFFF_FFFF);
    apb_write(AddrThresh, 64'd0);
    random_phase(250, 8);
    wait_quiet();

    // receiver holds off while queries keep coming
    hold_cycles = 400;
    random_phase(30, 2);
    wait_quiet();

    apb_write(AddrWindow, 64'd20);
    apb_write(AddrThresh, 64'd5000);
    stall_en = 1'b0;
    idle_pct = 0;
    random_phase(200, 3);
    stall_en = 1'b1;
    idle_pct = 17;
    wait_quiet();
    apb_write(AddrWindow, 64'd60);
    apb_write(AddrThresh, 64'd256);
    random_phase(500, 64);
    wait_quiet();
    apb_write(AddrWindow, 64'd7);
    random_phase(250, 6);

    wait_quiet();
    if (n_errors == 0 && rate_expected_q.size() == 0) begin
      $display("[windowed_change_rate_table] OK");
    end else begin
      $display("[windowed_change_rate_table] ERROR");
    end
    $finish;
  end
endmodule
